FILE: hdl/complex_arithmetic_unit_assert.svh
// Assertion macros shared by the complex arithmetic unit RTL.
// No dependencies; taken in by `include in the files that assert.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CAU_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/cau_pkg.sv
// Package of the complex arithmetic unit: widths, codes, stage structs and saturation.
// No dependencies; every RTL module imports it.
`default_nettype none
package cau_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * DATA_W;
    localparam int PRE_W  = PROD_W + 1;
    localparam int QUO_W  = DATA_W + 1;
    localparam int SMAG_W = PROD_W - FRAC_W;
    localparam int STEPS  = QUO_W;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;
    localparam logic [1:0] ST_RSVD = 2'd3;

    localparam logic [DATA_W-1:0] DMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] DMIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Operands after the products have been combined.
    typedef struct packed {
        op_t                      mode;
        logic signed [PRE_W-1:0]  pre_re;
        logic signed [PRE_W-1:0]  pre_im;
        logic [PROD_W-1:0]        den;
    } comb_t;

    // One part of a division in flight.
    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [PROD_W-1:0] rem;
        logic [QUO_W-1:0]  dvd;
        logic [QUO_W-1:0]  quo;
    } dpart_t;

    // Everything one beat carries through the divider stages.
    typedef struct packed {
        logic              is_div;
        logic              zden;
        logic [DATA_W-1:0] res_re;
        logic [DATA_W-1:0] res_im;
        logic [1:0]        status;
        logic [PROD_W-1:0] den;
        dpart_t            re;
        dpart_t            im;
    } dstage_t;

    // Saturates a sign and magnitude to the signed result range.
    // The top bit of the return value flags saturation.
    function automatic logic [DATA_W:0] sat_fn(input logic neg,
                                               input logic [SMAG_W-1:0] mag);
        logic [SMAG_W-1:0] lim;
        lim = SMAG_W'(1) << (DATA_W - 1);
        if (!neg) begin
            if (mag >= lim) begin
                return {1'b1, DMAX};
            end
            return {1'b0, mag[DATA_W-1:0]};
        end
        if (mag > lim) begin
            return {1'b1, DMIN};
        end
        return {1'b0, DATA_W'(~mag[DATA_W-1:0] + 1'b1)};
    endfunction

endpackage
`default_nettype wire

FILE: hdl/cau_mult.sv
// Multiplier front end: forms the six products, then combines them per operation.
// Depends on cau_pkg.
`default_nettype none
module cau_mult (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        mode,
    input  logic signed [cau_pkg::DATA_W-1:0] a_re,
    input  logic signed [cau_pkg::DATA_W-1:0] a_im,
    input  logic signed [cau_pkg::DATA_W-1:0] b_re,
    input  logic signed [cau_pkg::DATA_W-1:0] b_im,
    output logic                              out_valid,
    input  logic                              out_ready,
    output cau_pkg::comb_t                    out_data
);
    import cau_pkg::*;

    logic                      v1_reg;
    op_t                       mode1_reg;
    logic signed [PROD_W-1:0]  p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic [PROD_W-1:0]         sq_r_reg, sq_i_reg;
    logic [DATA_W:0]           as_re_reg, as_im_reg;
    logic [DATA_W:0]           as_re_next, as_im_next;
    logic                      ready1, ready2;
    logic                      v2_reg;
    comb_t                     comb_reg, comb_next;

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    // Sum or difference for the add and subtract operations.
    always_comb begin
        if (op_t'(mode) == OP_SUB) begin
            as_re_next = {a_re[DATA_W-1], a_re} - {b_re[DATA_W-1], b_re};
            as_im_next = {a_im[DATA_W-1], a_im} - {b_im[DATA_W-1], b_im};
        end else begin
            as_re_next = {a_re[DATA_W-1], a_re} + {b_re[DATA_W-1], b_re};
            as_im_next = {a_im[DATA_W-1], a_im} + {b_im[DATA_W-1], b_im};
        end
    end

    // Stage one: products.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ready1) begin
            v1_reg <= in_valid;
        end
        if (ready1 && in_valid) begin
            mode1_reg <= op_t'(mode);
            p_rr_reg  <= a_re * b_re;
            p_ii_reg  <= a_im * b_im;
            p_ri_reg  <= a_re * b_im;
            p_ir_reg  <= a_im * b_re;
            sq_r_reg  <= b_re * b_re;
            sq_i_reg  <= b_im * b_im;
            as_re_reg <= as_re_next;
            as_im_reg <= as_im_next;
        end
    end

    // Combine the products as the operation requires.
    always_comb begin
        comb_next      = '0;
        comb_next.mode = mode1_reg;
        comb_next.den  = sq_r_reg + sq_i_reg;
        case (mode1_reg) inside
            OP_ADD, OP_SUB: begin
                comb_next.pre_re = {{(PRE_W-DATA_W-1){as_re_reg[DATA_W]}}, as_re_reg};
                comb_next.pre_im = {{(PRE_W-DATA_W-1){as_im_reg[DATA_W]}}, as_im_reg};
            end
            OP_MUL: begin
                comb_next.pre_re = PRE_W'(p_rr_reg) - PRE_W'(p_ii_reg);
                comb_next.pre_im = PRE_W'(p_ri_reg) + PRE_W'(p_ir_reg);
            end
            default: begin
                comb_next.pre_re = PRE_W'(p_rr_reg) + PRE_W'(p_ii_reg);
                comb_next.pre_im = PRE_W'(p_ir_reg) - PRE_W'(p_ri_reg);
            end
        endcase
    end

    // Stage two: combined values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ready2) begin
            v2_reg <= v1_reg;
        end
        if (ready2 && v1_reg) begin
            comb_reg <= comb_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = comb_reg;

endmodule
`default_nettype wire

FILE: hdl/cau_prep.sv
// Preparation stage: finishes add, subtract and multiply, and sets up the division.
// Depends on cau_pkg.
`default_nettype none
module cau_prep (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  cau_pkg::comb_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cau_pkg::dstage_t  out_data
);
    import cau_pkg::*;

    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_W - 1);

    logic                      valid_reg;
    dstage_t                   data_reg, data_next;
    logic                      neg_re, neg_im;
    logic [PROD_W-1:0]         mag_re, mag_im;
    logic [PROD_W-1:0]         rnd_re, rnd_im;
    logic [SMAG_W-1:0]         sm_re, sm_im;
    logic [DATA_W:0]           sat_re, sat_im;
    logic [PROD_W+FRAC_W-1:0]  dfull_re, dfull_im;

    function automatic logic [PROD_W-1:0] abs_fn(input logic signed [PRE_W-1:0] x);
        logic [PRE_W-1:0] n;
        n = x[PRE_W-1] ? (~x + 1'b1) : x;
        return n[PROD_W-1:0];
    endfunction

    // Magnitudes, rounding and saturation of the non-dividing operations.
    always_comb begin
        neg_re   = in_data.pre_re[PRE_W-1];
        neg_im   = in_data.pre_im[PRE_W-1];
        mag_re   = abs_fn(in_data.pre_re);
        mag_im   = abs_fn(in_data.pre_im);
        rnd_re   = mag_re + HALF;
        rnd_im   = mag_im + HALF;
        if (in_data.mode == OP_MUL) begin
            sm_re = rnd_re[PROD_W-1:FRAC_W];
            sm_im = rnd_im[PROD_W-1:FRAC_W];
        end else begin
            sm_re = mag_re[SMAG_W-1:0];
            sm_im = mag_im[SMAG_W-1:0];
        end
        sat_re   = sat_fn(neg_re, sm_re);
        sat_im   = sat_fn(neg_im, sm_im);
        dfull_re = {mag_re, {FRAC_W{1'b0}}};
        dfull_im = {mag_im, {FRAC_W{1'b0}}};

        data_next        = '0;
        data_next.is_div = (in_data.mode == OP_DIV);
        data_next.zden   = (in_data.den == '0);
        data_next.den    = in_data.den;
        data_next.res_re = sat_re[DATA_W-1:0];
        data_next.res_im = sat_im[DATA_W-1:0];
        data_next.status = (sat_re[DATA_W] || sat_im[DATA_W]) ? ST_OVF : ST_OK;

        // The dividend is the magnitude shifted up by the fraction bits; the
        // remainder starts from the bits above the quotient.
        data_next.re.neg = neg_re;
        data_next.re.rem = PROD_W'(dfull_re >> QUO_W);
        data_next.re.ovf = (PROD_W'(dfull_re >> QUO_W) >= in_data.den);
        data_next.re.dvd = dfull_re[QUO_W-1:0];
        data_next.im.neg = neg_im;
        data_next.im.rem = PROD_W'(dfull_im >> QUO_W);
        data_next.im.ovf = (PROD_W'(dfull_im >> QUO_W) >= in_data.den);
        data_next.im.dvd = dfull_im[QUO_W-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

FILE: hdl/cau_div_step.sv
// One restoring division step for both parts, one quotient bit per stage.
// Depends on cau_pkg.
`default_nettype none
module cau_div_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  cau_pkg::dstage_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cau_pkg::dstage_t  out_data
);
    import cau_pkg::*;

    logic    valid_reg;
    dstage_t data_reg, data_next;

    function automatic dpart_t step_fn(input dpart_t p, input logic [PROD_W-1:0] den);
        dpart_t            r;
        logic [PROD_W-1:0] t;
        logic              qb;
        r  = p;
        t  = {p.rem[PROD_W-2:0], p.dvd[QUO_W-1]};
        qb = (t >= den);
        r.rem = qb ? (t - den) : t;
        r.dvd = {p.dvd[QUO_W-2:0], 1'b0};
        r.quo = {p.quo[QUO_W-2:0], qb};
        return r;
    endfunction

    // Shift in the next dividend bit and subtract where it fits.
    always_comb begin
        data_next    = in_data;
        data_next.re = step_fn(in_data.re, in_data.den);
        data_next.im = step_fn(in_data.im, in_data.den);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

FILE: hdl/cau_final.sv
// Output stage: rounds and saturates the quotients and holds the result beat.
// Depends on cau_pkg.
`default_nettype none
module cau_final (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  cau_pkg::dstage_t           in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [cau_pkg::DATA_W-1:0] res_re,
    output logic [cau_pkg::DATA_W-1:0] res_im,
    output logic [1:0]                 status
);
    import cau_pkg::*;

    logic              valid_reg;
    logic [DATA_W-1:0] re_reg, im_reg, re_next, im_next;
    logic [1:0]        st_reg, st_next;
    logic [DATA_W:0]   q_re, q_im;

    function automatic logic [DATA_W:0] fin_fn(input dpart_t p, input logic [PROD_W-1:0] den);
        logic            rup;
        logic [QUO_W:0]  qr;
        logic [SMAG_W-1:0] mag;
        rup = ({p.rem, 1'b0} >= {1'b0, den});
        qr  = {1'b0, p.quo} + {{QUO_W{1'b0}}, rup};
        mag = p.ovf ? {SMAG_W{1'b1}} : SMAG_W'(qr);
        return sat_fn(p.neg, mag);
    endfunction

    // Pick the division result, the divide-by-zero result or the one finished earlier.
    always_comb begin
        q_re = fin_fn(in_data.re, in_data.den);
        q_im = fin_fn(in_data.im, in_data.den);
        if (!in_data.is_div) begin
            re_next = in_data.res_re;
            im_next = in_data.res_im;
            st_next = in_data.status;
        end else if (in_data.zden) begin
            re_next = '0;
            im_next = '0;
            st_next = ST_DIVZ;
        end else begin
            re_next = q_re[DATA_W-1:0];
            im_next = q_im[DATA_W-1:0];
            st_next = (q_re[DATA_W] || q_im[DATA_W]) ? ST_OVF : ST_OK;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            re_reg <= re_next;
            im_reg <= im_next;
            st_reg <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign res_re    = re_reg;
    assign res_im    = im_reg;
    assign status    = st_reg;

endmodule
`default_nettype wire

FILE: hdl/complex_arithmetic_unit.sv
// Complex add, subtract, multiply and divide in signed Q16.16 with saturation.
// An accepted input beat passes to its result beat through two multiplier stages,
// one preparation stage, 33 restoring divider stages and the output register.
// Throughput is one beat per cycle while m_ready is high; every stage holds its beat while the next one stalls.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
`default_nettype none
`include "complex_arithmetic_unit_assert.svh"
module complex_arithmetic_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_mode,
    input  logic signed [cau_pkg::DATA_W-1:0] s_a_re,
    input  logic signed [cau_pkg::DATA_W-1:0] s_a_im,
    input  logic signed [cau_pkg::DATA_W-1:0] s_b_re,
    input  logic signed [cau_pkg::DATA_W-1:0] s_b_im,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [cau_pkg::DATA_W-1:0] m_res_re,
    output logic signed [cau_pkg::DATA_W-1:0] m_res_im,
    output logic [1:0]                        m_status
);
    import cau_pkg::*;

    logic    mul_valid, mul_ready;
    comb_t   mul_data;
    logic    stg_valid [0:STEPS];
    logic    stg_ready [0:STEPS];
    dstage_t stg_data  [0:STEPS];

    // Products and their combination.
    cau_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .mode      (s_mode),
        .a_re      (s_a_re),
        .a_im      (s_a_im),
        .b_re      (s_b_re),
        .b_im      (s_b_im),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .out_data  (mul_data)
    );

    // Non-dividing results and divider set-up.
    cau_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_data   (mul_data),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    // Divider pipeline, one quotient bit per stage.
    for (genvar k = 0; k < STEPS; k++) begin : g_div
        cau_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_data   (stg_data[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_data  (stg_data[k+1])
        );
    end

    // Rounding, saturation and the output register.
    cau_final u_final (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stg_valid[STEPS]),
        .in_ready  (stg_ready[STEPS]),
        .in_data   (stg_data[STEPS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .res_re    (m_res_re),
        .res_im    (m_res_im),
        .status    (m_status)
    );

    `CAU_ASSERT_IMP(a_status_code, aclk, aresetn, m_valid, m_status != ST_RSVD,
        "Result beat carries an unused status code.")
    `CAU_ASSERT_IMP(a_divz_zero, aclk, aresetn, m_valid && m_status == ST_DIVZ,
        m_res_re == '0 && m_res_im == '0, "Divide by zero gave a non-zero result.")
    `CAU_ASSERT_IMP(a_ovf_limit, aclk, aresetn, m_valid && m_status == ST_OVF,
        m_res_re == DMAX || m_res_re == DMIN || m_res_im == DMAX || m_res_im == DMIN,
        "Overflow status without a saturated part.")
    `CAU_ASSERT_NXT(a_div_hold, aclk, aresetn, stg_valid[STEPS] && !stg_ready[STEPS],
        stg_valid[STEPS], "Last divider stage dropped a stalled beat.")

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the complex arithmetic unit: directed and random beats.
// Depends on cau_pkg and the complex_arithmetic_unit RTL; it needs nothing else.
`timescale 1ns / 100ps
module tb;
    import cau_pkg::*;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic [1:0]  status;
    } cplx_res_t;

    // Works out the expected complex result of each accepted beat and checks results in order.
    class cplx_result_book;
        cplx_res_t awaited[$];
        int        errors;
        int        checked;
        int        ops_seen[4];

        function new();
            errors  = 0;
            checked = 0;
            foreach (ops_seen[i]) ops_seen[i] = 0;
        endfunction

        // Clamps an exact value to the 32-bit signed range and flags saturation.
        static function logic [31:0] clamp(logic signed [127:0] v, inout bit ovf);
            if (v > 128'sd2147483647) begin
                ovf = 1;
                return DMAX;
            end
            if (v < -128'sd2147483648) begin
                ovf = 1;
                return DMIN;
            end
            return v[31:0];
        endfunction

        // Drops the fraction bits with rounding to nearest, ties away from zero.
        static function logic signed [127:0] round_q(logic signed [127:0] v);
            logic [127:0] mag;
            mag = (v < 0) ? -v : v;
            mag = (mag + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
            return (v < 0) ? -$signed(mag) : $signed(mag);
        endfunction

        // Scaled quotient num / den, rounded to nearest with ties away from zero.
        static function logic signed [127:0] div_q(logic signed [127:0] num,
                                                   logic [127:0] den);
            logic [127:0] mag;
            logic [127:0] q;
            logic [127:0] r;
            mag = (num < 0) ? -num : num;
            q = (mag << FRAC_W) / den;
            r = (mag << FRAC_W) % den;
            if ((r << 1) >= den) q = q + 1;
            return (num < 0) ? -$signed(q) : $signed(q);
        endfunction

        function void note_operands(op_t op, logic signed [31:0] ar, logic signed [31:0] ai,
                                    logic signed [31:0] br, logic signed [31:0] bi);
            logic signed [127:0] wr;
            logic signed [127:0] wi;
            logic signed [127:0] den;
            logic signed [127:0] xr;
            logic signed [127:0] xi;
            logic signed [127:0] yr;
            logic signed [127:0] yi;
            cplx_res_t           e;
            bit                  ovf;
            xr = ar;
            xi = ai;
            yr = br;
            yi = bi;
            ovf = 0;
            ops_seen[op]++;
            case (op)
                OP_ADD: begin
                    wr = xr + yr;
                    wi = xi + yi;
                end
                OP_SUB: begin
                    wr = xr - yr;
                    wi = xi - yi;
                end
                OP_MUL: begin
                    wr = round_q(xr * yr - xi * yi);
                    wi = round_q(xr * yi + xi * yr);
                end
                default: begin
                    den = yr * yr + yi * yi;
                    if (den == 0) begin
                        e.re = '0;
                        e.im = '0;
                        e.status = ST_DIVZ;
                        awaited.push_back(e);
                        return;
                    end
                    wr = div_q(xr * yr + xi * yi, den);
                    wi = div_q(xi * yr - xr * yi, den);
                end
            endcase
            e.re = clamp(wr, ovf);
            e.im = clamp(wi, ovf);
            e.status = ovf ? ST_OVF : ST_OK;
            awaited.push_back(e);
        endfunction

        function void check_result(logic [31:0] re, logic [31:0] im, logic [1:0] status);
            cplx_res_t e;
            if (awaited.size() == 0) begin
                $error("result beat with nothing awaited: re=%h im=%h status=%0d",
                       re, im, status);
                errors++;
                return;
            end
            e = awaited.pop_front();
            checked++;
            if (re !== e.re) begin
                $error("res_re: expected %h, actual %h", e.re, re);
                errors++;
            end
            if (im !== e.im) begin
                $error("res_im: expected %h, actual %h", e.im, im);
                errors++;
            end
            if (status !== e.status) begin
                $error("status: expected %0d, actual %0d", e.status, status);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic signed [31:0] s_a_re;
    logic signed [31:0] s_a_im;
    logic signed [31:0] s_b_re;
    logic signed [31:0] s_b_im;
    logic        m_valid;
    logic        m_ready;
    logic signed [31:0] m_res_re;
    logic signed [31:0] m_res_im;
    logic [1:0]  m_status;

    cplx_result_book book;
    bit              quiet;
    int              results_seen;

    complex_arithmetic_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_mode   (s_mode),
        .s_a_re   (s_a_re),
        .s_a_im   (s_a_im),
        .s_b_re   (s_b_re),
        .s_b_im   (s_b_im),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res_re (m_res_re),
        .m_res_im (m_res_im),
        .m_status (m_status)
    );

    // Clock with a 4 ns period.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Generous ceiling on the run time.
    initial begin
        #2000000;
        $display("FAIL complex_arithmetic_unit");
        $finish;
    end

    // Notes every accepted input beat and checks every accepted result beat.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            book.note_operands(op_t'(s_mode), s_a_re, s_a_im, s_b_re, s_b_im);
        end
        if (aresetn && m_valid && m_ready) begin
            book.check_result(m_res_re, m_res_im, m_status);
            results_seen++;
        end
    end

    // Offers one beat after a random gap, or none when quiet, and holds it until it is taken.
    task automatic send_beat(op_t op, logic [31:0] ar, logic [31:0] ai,
                             logic [31:0] br, logic [31:0] bi);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= op;
        s_a_re  <= ar;
        s_a_im  <= ai;
        s_b_re  <= br;
        s_b_im  <= bi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // A random operand part: extremes, zero, small values, whole numbers or values spread over the range.
    function automatic logic [31:0] pick_part();
        case ($urandom_range(0, 7))
            0:       return DMAX;
            1:       return DMIN;
            2:       return '0;
            3:       return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
            4:       return ($urandom_range(0, 64) - 32) << FRAC_W;
            5:       return $urandom_range(0, 32'hFF) - 32'h7F;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stalls per beat, one long hold-off to back the pipeline up.
    initial begin
        int  gap;
        bit  held;
        held = 0;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && results_seen >= 300) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            gap = quiet ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Reset, directed beats, random beats, then drain and report.
    initial begin
        int waited;
        book = new();
        results_seen = 0;
        quiet   = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode  = OP_ADD;
        s_a_re  = '0;
        s_a_im  = '0;
        s_b_re  = '0;
        s_b_im  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Extremes of every operation, zero denominators, rounding ties and overflow.
        send_beat(OP_ADD, DMAX, DMIN, DMAX, DMIN);
        send_beat(OP_ADD, DMAX, DMIN, DMIN, DMAX);
        send_beat(OP_ADD, 32'h0001_0000, 32'hFFFF_8000, 32'h0000_4000, 32'h0000_8000);
        send_beat(OP_SUB, DMAX, DMIN, DMIN, DMAX);
        send_beat(OP_SUB, DMIN, '0, '0, DMIN);
        send_beat(OP_SUB, 32'h0003_0000, 32'h0000_0001, 32'h0003_0000, 32'h0000_0001);
        send_beat(OP_MUL, DMIN, DMIN, DMIN, DMIN);
        send_beat(OP_MUL, DMAX, DMIN, DMIN, DMAX);
        send_beat(OP_MUL, 32'h0000_0001, '0, 32'h0000_8000, '0);
        send_beat(OP_MUL, 32'hFFFF_FFFF, '0, 32'h0000_8000, '0);
        send_beat(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0000_8000);
        send_beat(OP_MUL, '0, '0, DMAX, DMIN);
        send_beat(OP_DIV, 32'h0001_0000, 32'h0002_0000, '0, '0);
        send_beat(OP_DIV, DMAX, DMIN, '0, '0);
        send_beat(OP_DIV, DMAX, DMAX, 32'h0000_0001, '0);
        send_beat(OP_DIV, DMIN, DMIN, DMIN, DMIN);
        send_beat(OP_DIV, DMIN, DMAX, '0, DMIN);
        send_beat(OP_DIV, 32'h0001_0000, '0, 32'h0003_0000, '0);
        send_beat(OP_DIV, 32'hFFFF_0000, '0, 32'h0003_0000, '0);
        send_beat(OP_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_beat(OP_DIV, '0, '0, 32'h0000_0001, 32'hFFFF_FFFF);

        // Random beats in blocks, some of them with no idling on either side.
        for (int i = 0; i < 830; i++) begin
            if (i % 100 == 0) quiet = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 19) == 0) begin
                send_beat(OP_DIV, pick_part(), pick_part(), '0, '0);
            end else begin
                send_beat(op_t'($urandom_range(0, 3)), pick_part(), pick_part(),
                          pick_part(), pick_part());
            end
        end
        s_valid <= 1'b0;
        quiet = 0;

        // Drain the pipeline, then allow for stray beats.
        waited = 0;
        while (book.awaited.size() != 0 && waited < 200000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (60) @(posedge aclk);

        $display("Checked %0d results: %0d add, %0d subtract, %0d multiply, %0d divide.",
                 book.checked, book.ops_seen[OP_ADD], book.ops_seen[OP_SUB],
                 book.ops_seen[OP_MUL], book.ops_seen[OP_DIV]);
        if (book.errors == 0 && book.awaited.size() == 0) begin
            $display("PASS complex_arithmetic_unit");
        end else begin
            if (book.awaited.size() != 0) begin
                $error("%0d expected results never arrived", book.awaited.size());
            end
            $display("FAIL complex_arithmetic_unit");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/cau_pkg.sv
hdl/cau_mult.sv
hdl/cau_prep.sv
hdl/cau_div_step.sv
hdl/cau_final.sv
hdl/complex_arithmetic_unit.sv
verif/tb.sv
